@@ design/bseb_pkg.sv @@
// Package for the bounded stack with bottom eviction.
// Holds action and status codes and the fixed field widths; no dependencies.
`default_nettype none

package bseb_pkg;

  // Fixed field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_CHANGE = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_EVICTED   = 2'd2
  } status_e;

endpackage

`default_nettype wire

@@ design/bounded_stack_evict_bottom_unit.sv @@
// Top level of the bounded stack with bottom eviction.
// Depends on bseb_pkg and bseb_ram.
//
//   channel | direction | handshake            | words
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid_i/in_ready_o| action_i, value_i, position_i
//   out     | output    | out_valid_o/out_ready_i | read_value_o, status_o, fill_count_o,
//           |           |                      | is_empty_o, is_full_o
//
// One word per cycle while the output is not stalled; a result passes the registered read
// of the slot RAM and then the output register before it shows.
// Slots live in a circular RAM; a push on a full stack writes over the bottom slot and
// advances the base pointer, so the eviction is one write.
// Reset clears fill level, base pointer and per-slot valid bits at once (no clearing pass);
// a slot that is not valid reads as zero.
// A stalled output holds one result and one more in the RAM read stage, then in_ready_o drops.
`default_nettype none

module bounded_stack_evict_bottom_unit #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic        [bseb_pkg::ACT_W-1:0]  action_i,
  input  wire logic signed [bseb_pkg::WORD_W-1:0] value_i,
  input  wire logic        [bseb_pkg::POS_W-1:0]  position_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed      [bseb_pkg::WORD_W-1:0] read_value_o,
  output logic             [bseb_pkg::STAT_W-1:0] status_o,
  output logic             [bseb_pkg::CNT_W-1:0]  fill_count_o,
  output logic                                    is_empty_o,
  output logic                                    is_full_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (AW + 1 > bseb_pkg::POS_W) ? AW + 1 : bseb_pkg::POS_W;
  localparam int unsigned WW = bseb_pkg::WORD_W;

  // Stack pointers and slot valid bits
  logic [FW-1:0]    fill_q, fill_d;
  logic [AW-1:0]    base_q, base_d;
  logic [DEPTH-1:0] vld_q, vld_d;

  // Read stage
  logic                  s2_valid_q, s2_valid_d;
  logic                  s2_use_q;
  bseb_pkg::status_e     s2_status_q;
  logic [FW-1:0]         s2_fill_q;
  logic                  s2_empty_q, s2_full_q;
  logic                  s2_go;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [WW-1:0]         out_value_q;
  bseb_pkg::status_e     out_status_q;
  logic [FW-1:0]         out_fill_q;
  logic                  out_empty_q, out_full_q;

  logic                  in_acc;
  bseb_pkg::action_e     act;
  logic                  full, empty, pos_ok;
  logic [XW-1:0]         logical;
  logic [XW:0]           sum, phys_wide;
  logic [AW-1:0]         phys, base_inc;
  logic                  ram_we, use_rd, clr_vld;
  bseb_pkg::status_e     status;
  logic [WW-1:0]         ram_rdata;
  logic [31:0]           fill_wide;

  assign s2_go      = !out_valid_q || out_ready_i;
  assign in_ready_o = !s2_valid_q || s2_go;
  assign in_acc     = in_valid_i && in_ready_o;
  assign act        = bseb_pkg::action_e'(action_i);

  assign full     = (fill_q == FW'(DEPTH));
  assign empty    = (fill_q == '0);
  assign pos_ok   = (32'(position_i) < 32'(DEPTH));
  assign base_inc = (base_q == AW'(DEPTH - 1)) ? '0 : base_q + 1'b1;

  // Decode the action against the current fill level
  always_comb begin
    logical = '0;
    ram_we  = 1'b0;
    use_rd  = 1'b0;
    clr_vld = 1'b0;
    status  = bseb_pkg::ST_OK;
    fill_d  = fill_q;
    base_d  = base_q;
    unique case (act)
      bseb_pkg::ACT_PUSH: begin
        logical = XW'(fill_q);
        ram_we  = 1'b1;
        if (full) begin
          base_d = base_inc;
          status = bseb_pkg::ST_EVICTED;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      bseb_pkg::ACT_POP: begin
        logical = XW'(fill_q) - 1'b1;
        if (empty) begin
          status = bseb_pkg::ST_UNDERFLOW;
        end else begin
          fill_d  = fill_q - 1'b1;
          use_rd  = 1'b1;
          clr_vld = 1'b1;
        end
      end
      bseb_pkg::ACT_PEEK: begin
        logical = XW'(position_i);
        if (empty) begin
          status = bseb_pkg::ST_UNDERFLOW;
        end else begin
          use_rd = pos_ok;
        end
      end
      bseb_pkg::ACT_CHANGE: begin
        logical = XW'(position_i);
        ram_we  = pos_ok;
      end
      default: begin
        logical = '0;
      end
    endcase
  end

  // Logical slot to physical RAM address, circular over DEPTH
  assign sum       = {1'b0, XW'(base_q)} + {1'b0, logical};
  assign phys_wide = (sum >= (XW + 1)'(DEPTH)) ? sum - (XW + 1)'(DEPTH) : sum;
  assign phys      = phys_wide[AW-1:0];

  // Valid bits: set on write, cleared on pop
  always_comb begin
    vld_d = vld_q;
    if (in_acc && ram_we) begin
      vld_d[phys] = 1'b1;
    end
    if (in_acc && clr_vld) begin
      vld_d[phys] = 1'b0;
    end
  end

  assign s2_valid_d  = in_acc ? 1'b1 : (s2_go ? 1'b0 : s2_valid_q);
  assign out_valid_d = (s2_valid_q && s2_go) ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      base_q      <= '0;
      vld_q       <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        fill_q <= fill_d;
        base_q <= base_d;
      end
      vld_q       <= vld_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s2_use_q    <= use_rd && vld_q[phys];
      s2_status_q <= status;
      s2_fill_q   <= fill_d;
      s2_empty_q  <= (fill_d == '0);
      s2_full_q   <= (fill_d == FW'(DEPTH));
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s2_go) begin
      out_value_q  <= s2_use_q ? ram_rdata : '0;
      out_status_q <= s2_status_q;
      out_fill_q   <= s2_fill_q;
      out_empty_q  <= s2_empty_q;
      out_full_q   <= s2_full_q;
    end
  end

  bseb_ram #(
    .Width (WW),
    .Depth (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (in_acc && ram_we),
    .waddr_i (phys),
    .wdata_i (value_i),
    .re_i    (in_acc),
    .raddr_i (phys),
    .rdata_o (ram_rdata)
  );

  assign fill_wide    = 32'(out_fill_q);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;
  assign fill_count_o = fill_wide[bseb_pkg::CNT_W-1:0];
  assign is_empty_o   = out_empty_q;
  assign is_full_o    = out_full_q;

endmodule

`default_nettype wire

@@ design/bseb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bseb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/bseb_chk.sv @@
// Port-level checker for the bounded stack with bottom eviction, plus its bind.
// Depends on bseb_pkg; binds to bounded_stack_evict_bottom_unit.
`default_nettype none

module bseb_chk (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [bseb_pkg::WORD_W-1:0]  read_value_o,
  input wire logic [bseb_pkg::STAT_W-1:0]  status_o,
  input wire logic [bseb_pkg::CNT_W-1:0]   fill_count_o,
  input wire logic                         is_empty_o,
  input wire logic                         is_full_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o) && $stable(status_o))
    else $error("result word changed while stalled");

  // Empty means a zero count and never full
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> fill_count_o == '0 && !is_full_o)
    else $error("empty flag disagrees with count");

  // Underflow only on an empty stack and reads zero
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bseb_pkg::ST_UNDERFLOW |-> is_empty_o && read_value_o == '0)
    else $error("underflow on non-empty stack or nonzero data");

  // Eviction leaves the stack full and returns no data
  a_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bseb_pkg::ST_EVICTED |-> is_full_o && read_value_o == '0)
    else $error("eviction without full stack");

endmodule

bind bounded_stack_evict_bottom_unit bseb_chk u_bseb_chk (.*);

`default_nettype wire
